// File: rtl/spd_pkg.sv
// Package with shared types, codes and constants for the shortest path distance block.
package spd_pkg;

    localparam int NODE_BITS        = 6;
    localparam int COUNT_BITS       = 7;
    localparam int IN_WEIGHT_BITS   = 16;
    localparam int DIST_BITS        = 31;
    localparam int DEF_MAX_NODES    = 64;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int DEF_WEIGHT_BITS  = 16;
    localparam int CFG_WIDTH        = 7;

    localparam logic [DIST_BITS-1:0] INT_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic CFG_NODE_COUNT  = 1'b0;
    localparam logic CFG_SOURCE_NODE = 1'b1;

    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET  = 7'd64;
    localparam logic [NODE_BITS-1:0]  SOURCE_NODE_RESET = 6'd0;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [NODE_BITS-1:0]      edge_from;
        logic [NODE_BITS-1:0]      edge_to;
        logic [IN_WEIGHT_BITS-1:0] edge_weight;
        logic                      both_ways;
    } t_in;

    typedef struct packed {
        logic [NODE_BITS-1:0] node_index;
        logic [DIST_BITS-1:0] distance;
        logic                 unreachable;
        logic                 edges_dropped;
        logic                 last;
    } t_out;

endpackage

// File: rtl/spd_ram.sv
// Generic single-port RAM with registered read.
module spd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/spd_alu.sv
// Shared add and compare unit used by both the minimum scan and edge relaxation.
module spd_alu #(
    parameter int WEIGHT_BITS = spd_pkg::DEF_WEIGHT_BITS
) (
    input  logic [spd_pkg::DIST_BITS-1:0] i_base,
    input  logic [WEIGHT_BITS-1:0]        i_addend,
    input  logic [spd_pkg::DIST_BITS-1:0] i_limit,
    output logic [spd_pkg::DIST_BITS-1:0] o_sum,
    output logic                          o_less
);

    logic [spd_pkg::DIST_BITS:0] sum;

    // The sum stays far below the 32-bit range, so the carry never matters.
    assign sum    = {1'b0, i_base} + (spd_pkg::DIST_BITS + 1)'(i_addend);
    assign o_sum  = sum[spd_pkg::DIST_BITS-1:0];
    assign o_less = sum < {1'b0, i_limit};

endmodule

// File: rtl/shortest_path_distances.sv
// Top level of the single-source shortest path distance block.
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid / o_in_stall  i_in_data  (spd_pkg::t_in)
//  output    out        o_out_valid / i_out_stall o_out_data (spd_pkg::t_out)
//  config    in         i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// An add item stores one edge, or two when the edge is stored both ways; a clear empties the store.
// A run first fills all MAX_NODES entries of the distance memory and then writes the source, then
// per settled node scans all n nodes and walks every stored edge, relaxing each one that hits,
// and ends with n results, each held through any output stall. Reset is synchronous and active
// low and clears the edge count, the overflow flag and the control registers. The input stalls
// while any item is in progress.
module shortest_path_distances #(
    parameter int MAX_NODES   = spd_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = spd_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = spd_pkg::DEF_WEIGHT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  spd_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output spd_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [spd_pkg::CFG_WIDTH-1:0] i_cfg_wdata
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * spd_pkg::NODE_BITS + WEIGHT_BITS;
    localparam int CW  = spd_pkg::COUNT_BITS;
    localparam int NB  = spd_pkg::NODE_BITS;
    localparam int DB  = spd_pkg::DIST_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD2,
        ST_INIT,
        ST_SRC,
        ST_SCAN,
        ST_RLX_RD,
        ST_RLX_CHK,
        ST_RLX_CMP,
        ST_OUT_ISSUE,
        ST_OUT_LOAD,
        ST_OUT_HOLD
    } t_state;

    t_state                r_state;
    logic [CW-1:0]         r_node_count;
    logic [NB-1:0]         r_source;
    logic [ECW-1:0]        r_total;
    logic                  r_overflow;
    logic [EW-1:0]         r_pend;
    logic [CW-1:0]         r_i;
    logic                  r_pv;
    logic [NW-1:0]         r_pi;
    logic                  r_found;
    logic [NW-1:0]         r_best;
    logic [DB-1:0]         r_bd;
    logic [ECW-1:0]        r_e;
    logic [MAX_NODES-1:0]  r_settled;
    logic                  r_out_valid;
    spd_pkg::t_out         r_out;

    logic [CW-1:0]          n_eff;
    logic                   in_accept;
    logic                   edge_bad;
    logic                   edge_full;
    logic [WEIGHT_BITS-1:0] in_weight;

    logic                   e_we;
    logic                   e_re;
    logic [EAW-1:0]         e_addr;
    logic [EW-1:0]          e_wdata;
    logic [EW-1:0]          e_rdata;
    logic [NB-1:0]          e_from;
    logic [NB-1:0]          e_to;
    logic [WEIGHT_BITS-1:0] e_weight;

    logic                   d_we;
    logic                   d_re;
    logic [NW-1:0]          d_addr;
    logic [DB-1:0]          d_wdata;
    logic [DB-1:0]          d_rdata;

    logic [DB-1:0]          alu_base;
    logic [WEIGHT_BITS-1:0] alu_addend;
    logic [DB-1:0]          alu_limit;
    logic [DB-1:0]          alu_sum;
    logic                   alu_less;

    logic                   rlx_hit;
    logic                   out_last;

    // A node count of zero acts as one, and counts above capacity saturate.
    always_comb begin
        if (r_node_count == '0) begin
            n_eff = CW'(1);
        end else if (r_node_count > CW'(MAX_NODES)) begin
            n_eff = CW'(MAX_NODES);
        end else begin
            n_eff = r_node_count;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_weight  = WEIGHT_BITS'(i_in_data.edge_weight);

    // An edge is rejected for a bad endpoint or weight, or when its entries do not fit.
    assign edge_bad = ({1'b0, i_in_data.edge_from} >= n_eff)
                   || ({1'b0, i_in_data.edge_to} >= n_eff)
                   || ((i_in_data.edge_weight >> WEIGHT_BITS) != '0);
    assign edge_full = ({1'b0, r_total} + (ECW + 1)'(i_in_data.both_ways ? 2 : 1))
                     > (ECW + 1)'(MAX_EDGES);

    assign e_from   = e_rdata[EW-1 -: NB];
    assign e_to     = e_rdata[EW-NB-1 -: NB];
    assign e_weight = e_rdata[WEIGHT_BITS-1:0];

    assign rlx_hit = (e_from == NB'(r_best)) && ({1'b0, e_to} < n_eff)
                  && !r_settled[e_to[NW-1:0]];

    assign out_last = ((r_i + CW'(1)) == n_eff);

    // Edge store port.
    always_comb begin
        e_we    = 1'b0;
        e_re    = 1'b0;
        e_addr  = r_e[EAW-1:0];
        e_wdata = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                e_addr  = r_total[EAW-1:0];
                e_wdata = {i_in_data.edge_from, i_in_data.edge_to, in_weight};
                e_we    = in_accept && (i_in_data.req_type == spd_pkg::REQ_ADD)
                       && !edge_bad && !edge_full;
            end
            ST_ADD2: begin
                e_addr = r_total[EAW-1:0];
                e_we   = 1'b1;
            end
            ST_RLX_RD: begin
                e_re = (r_e < r_total);
            end
            default: begin
            end
        endcase
    end

    // Distance memory port.
    always_comb begin
        d_we    = 1'b0;
        d_re    = 1'b0;
        d_addr  = r_i[NW-1:0];
        d_wdata = spd_pkg::INT_MAX;
        unique case (r_state)
            ST_INIT: begin
                d_we = 1'b1;
            end
            ST_SRC: begin
                d_addr  = r_source[NW-1:0];
                d_wdata = '0;
                d_we    = ({1'b0, r_source} < n_eff);
            end
            ST_SCAN: begin
                d_re = (r_i < n_eff);
            end
            ST_RLX_CHK: begin
                d_addr = e_to[NW-1:0];
                d_re   = rlx_hit;
            end
            ST_RLX_CMP: begin
                d_addr  = e_to[NW-1:0];
                d_wdata = alu_sum;
                d_we    = alu_less;
            end
            ST_OUT_ISSUE: begin
                d_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // The shared unit compares a scanned distance against the best so far, or
    // forms a relaxation candidate and compares it against the stored distance.
    always_comb begin
        if (r_state == ST_RLX_CMP) begin
            alu_base   = r_bd;
            alu_addend = e_weight;
            alu_limit  = d_rdata;
        end else begin
            alu_base   = d_rdata;
            alu_addend = '0;
            alu_limit  = r_bd;
        end
    end

    spd_alu #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) u_alu (
        .i_base  (alu_base),
        .i_addend(alu_addend),
        .i_limit (alu_limit),
        .o_sum   (alu_sum),
        .o_less  (alu_less)
    );

    spd_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_EDGES)
    ) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_re   (e_re),
        .i_addr (e_addr),
        .i_wdata(e_wdata),
        .o_rdata(e_rdata)
    );

    spd_ram #(
        .WIDTH(DB),
        .DEPTH(MAX_NODES)
    ) u_dist_ram (
        .i_clk  (i_clk),
        .i_we   (d_we),
        .i_re   (d_re),
        .i_addr (d_addr),
        .i_wdata(d_wdata),
        .o_rdata(d_rdata)
    );

    // Sequencer: loads, run setup, minimum scan, edge relaxation and result output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_node_count <= spd_pkg::NODE_COUNT_RESET;
            r_source     <= spd_pkg::SOURCE_NODE_RESET;
            r_total      <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_i          <= '0;
            r_pv         <= 1'b0;
            r_found      <= 1'b0;
            r_e          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spd_pkg::CFG_NODE_COUNT:  r_node_count <= i_cfg_wdata;
                    spd_pkg::CFG_SOURCE_NODE: r_source     <= i_cfg_wdata[NB-1:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        unique case (i_in_data.req_type)
                            spd_pkg::REQ_ADD: begin
                                if (edge_bad || edge_full) begin
                                    r_overflow <= 1'b1;
                                end else begin
                                    r_total <= r_total + ECW'(1);
                                    r_pend  <= {i_in_data.edge_to, i_in_data.edge_from,
                                                in_weight};
                                    if (i_in_data.both_ways) begin
                                        r_state <= ST_ADD2;
                                    end
                                end
                            end
                            spd_pkg::REQ_RUN: begin
                                r_i       <= '0;
                                r_settled <= '0;
                                r_state   <= ST_INIT;
                            end
                            spd_pkg::REQ_CLEAR: begin
                                r_total    <= '0;
                                r_overflow <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_ADD2: begin
                    r_total <= r_total + ECW'(1);
                    r_state <= ST_IDLE;
                end
                ST_INIT: begin
                    r_i <= r_i + CW'(1);
                    if (r_i == CW'(MAX_NODES - 1)) begin
                        r_state <= ST_SRC;
                    end
                end
                ST_SRC: begin
                    r_i     <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_bd    <= spd_pkg::INT_MAX;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    // Strict compare in ascending order keeps the lowest index on a tie.
                    if (r_pv && !r_settled[r_pi] && alu_less) begin
                        r_found <= 1'b1;
                        r_bd    <= d_rdata;
                        r_best  <= r_pi;
                    end
                    if (r_i < n_eff) begin
                        r_pv <= 1'b1;
                        r_pi <= r_i[NW-1:0];
                        r_i  <= r_i + CW'(1);
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_i <= '0;
                            if (r_found) begin
                                r_settled[r_best] <= 1'b1;
                                r_e               <= '0;
                                r_state           <= ST_RLX_RD;
                            end else begin
                                r_state <= ST_OUT_ISSUE;
                            end
                        end
                    end
                end
                ST_RLX_RD: begin
                    if (r_e < r_total) begin
                        r_state <= ST_RLX_CHK;
                    end else begin
                        r_i     <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                        r_bd    <= spd_pkg::INT_MAX;
                        r_state <= ST_SCAN;
                    end
                end
                ST_RLX_CHK: begin
                    if (rlx_hit) begin
                        r_state <= ST_RLX_CMP;
                    end else begin
                        r_e     <= r_e + ECW'(1);
                        r_state <= ST_RLX_RD;
                    end
                end
                ST_RLX_CMP: begin
                    r_e     <= r_e + ECW'(1);
                    r_state <= ST_RLX_RD;
                end
                ST_OUT_ISSUE: begin
                    r_state <= ST_OUT_LOAD;
                end
                ST_OUT_LOAD: begin
                    r_out.node_index    <= r_i[NB-1:0];
                    r_out.distance      <= d_rdata;
                    r_out.unreachable   <= (d_rdata == spd_pkg::INT_MAX);
                    r_out.edges_dropped <= r_overflow;
                    r_out.last          <= out_last;
                    r_out_valid         <= 1'b1;
                    r_state             <= ST_OUT_HOLD;
                end
                ST_OUT_HOLD: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_i     <= r_i + CW'(1);
                            r_state <= ST_OUT_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/spd_chk.sv
// Port-level checker for the shortest path distance block, bound to the top level.
module spd_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input spd_pkg::t_out o_out_data
);

    // A result waiting under stall holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // No new item is taken while a result is being delivered.
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // The final result of a run ends the run.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_data.last |=> !o_out_valid)
        else $error("result after last");

    // The unreachable flag agrees with the saturated distance.
    a_unreach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.unreachable == (o_out_data.distance == spd_pkg::INT_MAX)))
        else $error("unreachable flag mismatch");

endmodule

bind shortest_path_distances spd_chk u_spd_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
